// ----- hw/rtl/vfa_pkg.sv -----
// Shared mode codes, register type and reset value for the vector ALU.
package vfa_pkg;

   typedef logic [2:0] mode_type;

   localparam mode_type MODE_DOT    = 3'd0;
   localparam mode_type MODE_SCALE  = 3'd1;
   localparam mode_type MODE_NEGATE = 3'd2;
   localparam mode_type MODE_SUB    = 3'd3;
   localparam mode_type MODE_ADD    = 3'd4;
   localparam mode_type MODE_LENGTH = 3'd5;
   localparam mode_type MODE_NORM   = 3'd6;
   localparam mode_type MODE_CROSS  = 3'd7;

   localparam int EPS_WIDTH = 16;
   typedef logic [EPS_WIDTH-1:0] eps_type;
   localparam eps_type EPS_RESET = 16'd7;

endpackage

// ----- hw/rtl/vfa_if.sv -----
// Handshake channels of the vector ALU: operand, result and epsilon write.
interface vfa_req_if import vfa_pkg::*; #(
   parameter int W = 32
);
   logic         valid;
   logic         ready;
   mode_type     mode;
   logic [W-1:0] a_x;
   logic [W-1:0] a_y;
   logic [W-1:0] a_z;
   logic [W-1:0] a_w;
   logic [W-1:0] b_x;
   logic [W-1:0] b_y;
   logic [W-1:0] b_z;
   logic [W-1:0] b_w;
   logic [W-1:0] scalar_in;

   modport source (output valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   scalar_in, input ready);
   modport sink   (input valid, mode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                   scalar_in, output ready);
endinterface

interface vfa_rsp_if #(
   parameter int W = 32
);
   logic         valid;
   logic         ready;
   logic [W-1:0] result_x;
   logic [W-1:0] result_y;
   logic [W-1:0] result_z;
   logic [W-1:0] result_w;
   logic [W-1:0] scalar_out;
   logic         too_short;
   logic         saturated;

   modport source (output valid, result_x, result_y, result_z, result_w, scalar_out,
                   too_short, saturated, input ready);
   modport sink   (input valid, result_x, result_y, result_z, result_w, scalar_out,
                   too_short, saturated, output ready);
endinterface

interface vfa_csr_if import vfa_pkg::*;;
   logic    valid;
   logic    ready;
   eps_type epsilon_threshold;

   modport source (output valid, epsilon_threshold, input ready);
   modport sink   (input valid, epsilon_threshold, output ready);
endinterface

// ----- hw/rtl/vector4_fixed_point_alu.sv -----
// Default parameters give Q16.16 on 32-bit components.
// Throughput: one beat per cycle unless stalled; the square root spends one stage per
// root bit, the reciprocal one per quotient bit, so every mode rides the same pipe.
// A stalled result beat holds the whole pipe in place; ready follows the output slot.
// Reset (synchronous, active high) clears every stage valid and loads epsilon with 7.
// Epsilon writes are taken every cycle and act on items that reach the compare stage.
module vector4_fixed_point_alu import vfa_pkg::*; #(
   parameter int FRACTION_BITS   = 16,
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   vfa_csr_if.sink   csr_bus,
   vfa_req_if.sink   req_bus,
   vfa_rsp_if.source rsp_bus
);

   localparam int W  = COMPONENT_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int QB = 2 * F + 1;                 // reciprocal quotient bits
   localparam int XW = (2 * W + 3 > W + 2 * F + 3) ? 2 * W + 3 : W + 2 * F + 3;
   localparam int LW = (W > EPS_WIDTH) ? W : EPS_WIDTH;

   // Context that rides along the root and reciprocal stages.
   typedef struct packed {
      mode_type            mode;
      logic [3:0][W-1:0]   a;
      logic [4:0][W-1:0]   f;      // finished results of the non-root modes
      logic                fsat;
   } ctx_type;

   // Arithmetic shift by F, rounded toward zero.
   function automatic logic signed [XW-1:0] trunc_shift(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] q;
      q = v >>> F;
      if (v[XW-1] && (v[F-1:0] != '0)) begin
         q = q + XW'(1);
      end
      return q;
   endfunction

   // Clip to the signed W-bit range; bit W flags a clip.
   function automatic logic [W:0] clip_w(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] hi;
      logic signed [XW-1:0] lo;
      logic [W:0]           r;
      hi = $signed({{(XW-W+1){1'b0}}, {(W-1){1'b1}}});
      lo = ~hi;
      if (v > hi) begin
         r = {1'b1, hi[W-1:0]};
      end else if (v < lo) begin
         r = {1'b1, lo[W-1:0]};
      end else begin
         r = {1'b0, v[W-1:0]};
      end
      return r;
   endfunction

   function automatic logic signed [XW-1:0] sx(input logic [2*W-1:0] p);
      return XW'($signed(p));
   endfunction

   // Whole pipe moves unless the output beat is stuck.
   logic    adv;
   logic    rsp_vld_ff;
   eps_type eps_ff;

   assign adv           = !rsp_vld_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_bus.valid) begin
         eps_ff <= csr_bus.epsilon_threshold;
      end
   end

   // ---------------- stage 0: operand capture ----------------
   logic              s0_vld_ff;
   mode_type          s0_mode_ff;
   logic [3:0][W-1:0] s0_a_ff;
   logic [3:0][W-1:0] s0_b_ff;
   logic [W-1:0]      s0_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_mode_ff <= req_bus.mode;
         s0_a_ff    <= {req_bus.a_w, req_bus.a_z, req_bus.a_y, req_bus.a_x};
         s0_b_ff    <= {req_bus.b_w, req_bus.b_z, req_bus.b_y, req_bus.b_x};
         s0_s_ff    <= req_bus.scalar_in;
      end
   end

   // ---------------- stage 1: six shared multipliers, add/sub/negate ----------------
   logic [5:0][W-1:0]   opl;
   logic [5:0][W-1:0]   opr;
   logic [5:0][2*W-1:0] p1_in;
   logic [3:0][W:0]     sv_w;
   logic [3:0][W:0]     sc_w;
   logic [3:0][W-1:0]   simple_in;
   logic                ssat_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         opl[i] = s0_a_ff[i];
         opr[i] = s0_b_ff[i];
      end
      opl[4] = s0_a_ff[0];
      opr[4] = s0_b_ff[1];
      opl[5] = s0_a_ff[1];
      opr[5] = s0_b_ff[0];
      case (s0_mode_ff)
         MODE_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               opr[i] = s0_s_ff;
            end
         end
         MODE_LENGTH, MODE_NORM: begin
            for (int i = 0; i < 3; i++) begin
               opr[i] = s0_a_ff[i];
            end
         end
         MODE_CROSS: begin
            opl[0] = s0_a_ff[1];  opr[0] = s0_b_ff[2];
            opl[1] = s0_a_ff[2];  opr[1] = s0_b_ff[1];
            opl[2] = s0_a_ff[2];  opr[2] = s0_b_ff[0];
            opl[3] = s0_a_ff[0];  opr[3] = s0_b_ff[2];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         p1_in[i] = $signed(opl[i]) * $signed(opr[i]);
      end
   end

   always_comb begin
      ssat_in = 1'b0;
      for (int i = 0; i < 4; i++) begin
         case (s0_mode_ff)
            MODE_NEGATE: sv_w[i] = -$signed({s0_a_ff[i][W-1], s0_a_ff[i]});
            MODE_SUB:    sv_w[i] = $signed({s0_a_ff[i][W-1], s0_a_ff[i]})
                                 - $signed({s0_b_ff[i][W-1], s0_b_ff[i]});
            MODE_ADD:    sv_w[i] = $signed({s0_a_ff[i][W-1], s0_a_ff[i]})
                                 + $signed({s0_b_ff[i][W-1], s0_b_ff[i]});
            default:     sv_w[i] = '0;
         endcase
         sc_w[i]      = clip_w(XW'($signed(sv_w[i])));
         simple_in[i] = sc_w[i][W-1:0];
         ssat_in      = ssat_in | sc_w[i][W];
      end
   end

   logic                s1_vld_ff;
   mode_type            s1_mode_ff;
   logic [3:0][W-1:0]   s1_a_ff;
   logic [5:0][2*W-1:0] s1_p_ff;
   logic [3:0][W-1:0]   s1_simple_ff;
   logic                s1_ssat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff   <= s0_mode_ff;
         s1_a_ff      <= s0_a_ff;
         s1_p_ff      <= p1_in;
         s1_simple_ff <= simple_in;
         s1_ssat_ff   <= ssat_in;
      end
   end

   // ---------------- stage 2: product sums ----------------
   logic [3:0][XW-1:0] e2_in;
   logic [2*W-1:0]     sq2_in;

   always_comb begin
      e2_in  = '0;
      sq2_in = s1_p_ff[0] + s1_p_ff[1] + s1_p_ff[2];   // squares are never negative
      case (s1_mode_ff)
         MODE_DOT: begin
            e2_in[0] = sx(s1_p_ff[0]) + sx(s1_p_ff[1]) + sx(s1_p_ff[2]) + sx(s1_p_ff[3]);
         end
         MODE_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               e2_in[i] = sx(s1_p_ff[i]);
            end
         end
         MODE_CROSS: begin
            e2_in[0] = sx(s1_p_ff[0]) - sx(s1_p_ff[1]);
            e2_in[1] = sx(s1_p_ff[2]) - sx(s1_p_ff[3]);
            e2_in[2] = sx(s1_p_ff[4]) - sx(s1_p_ff[5]);
         end
         default: begin
         end
      endcase
   end

   logic               s2_vld_ff;
   mode_type           s2_mode_ff;
   logic [3:0][W-1:0]  s2_a_ff;
   logic [3:0][XW-1:0] s2_e_ff;
   logic [2*W-1:0]     s2_sq_ff;
   logic [3:0][W-1:0]  s2_simple_ff;
   logic               s2_ssat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_mode_ff   <= s1_mode_ff;
         s2_a_ff      <= s1_a_ff;
         s2_e_ff      <= e2_in;
         s2_sq_ff     <= sq2_in;
         s2_simple_ff <= s1_simple_ff;
         s2_ssat_ff   <= s1_ssat_ff;
      end
   end

   // ---------------- stage 3: round toward zero, clip ----------------
   logic [3:0][W:0] t_w;
   ctx_type         ctx3_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         t_w[i] = clip_w(trunc_shift($signed(s2_e_ff[i])));
      end
      ctx3_in      = '0;
      ctx3_in.mode = s2_mode_ff;
      ctx3_in.a    = s2_a_ff;
      case (s2_mode_ff)
         MODE_DOT: begin
            ctx3_in.f[4] = t_w[0][W-1:0];
            ctx3_in.fsat = t_w[0][W];
         end
         MODE_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               ctx3_in.f[i] = t_w[i][W-1:0];
            end
            ctx3_in.fsat = t_w[0][W] | t_w[1][W] | t_w[2][W] | t_w[3][W];
         end
         MODE_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               ctx3_in.f[i] = t_w[i][W-1:0];
            end
            ctx3_in.fsat = t_w[0][W] | t_w[1][W] | t_w[2][W];
         end
         MODE_NEGATE, MODE_SUB, MODE_ADD: begin
            for (int i = 0; i < 4; i++) begin
               ctx3_in.f[i] = s2_simple_ff[i];
            end
            ctx3_in.fsat = s2_ssat_ff;
         end
         default: begin
         end
      endcase
   end

   // ---------------- square root: one root bit per stage ----------------
   logic           sq_vld_ff  [W+1];
   ctx_type        sq_ctx_ff  [W+1];
   logic [2*W-1:0] sq_rad_ff  [W+1];
   logic [W+1:0]   sq_rem_ff  [W+1];
   logic [W-1:0]   sq_root_ff [W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ctx_ff[0]  <= ctx3_in;
         sq_rad_ff[0]  <= s2_sq_ff;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < W; k++) begin : g_sqrt
      logic [W+1:0] rem_t;
      logic [W+1:0] trial;
      logic [W+1:0] rem_in;
      logic [W-1:0] root_in;
      logic         take;

      // Bring down two radicand bits, try root*4+1.
      assign rem_t   = {sq_rem_ff[k][W-1:0], sq_rad_ff[k][2*W-1 -: 2]};
      assign trial   = {sq_root_ff[k], 2'b01};
      assign take    = (rem_t >= trial);
      assign rem_in  = take ? rem_t - trial : rem_t;
      assign root_in = {sq_root_ff[k][W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ctx_ff[k+1]  <= sq_ctx_ff[k];
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][2*W-3:0], 2'b00};
            sq_rem_ff[k+1]  <= rem_in;
            sq_root_ff[k+1] <= root_in;
         end
      end
   end

   // ---------------- epsilon check, then reciprocal: one quotient bit per stage ----------
   logic         short_in;
   logic         dv_vld_ff   [QB+1];
   ctx_type      dv_ctx_ff   [QB+1];
   logic [W-1:0] dv_len_ff   [QB+1];
   logic         dv_short_ff [QB+1];
   logic [W-1:0] dv_rem_ff   [QB+1];
   logic [QB-1:0] dv_q_ff    [QB+1];

   assign short_in = (sq_root_ff[W] == '0) || (LW'(sq_root_ff[W]) < LW'(eps_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ctx_ff[0]   <= sq_ctx_ff[W];
         dv_len_ff[0]   <= sq_root_ff[W];
         dv_short_ff[0] <= short_in;
         dv_rem_ff[0]   <= '0;
         dv_q_ff[0]     <= '0;
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_recip
      // Dividend is a one followed by 2*F zeros.
      localparam logic NUM_BIT = (k == 0);
      logic [W:0]    rem_t;
      logic [W:0]    rem_in;
      logic [QB-1:0] q_in;
      logic          take;

      assign rem_t  = {dv_rem_ff[k], NUM_BIT};
      assign take   = (rem_t >= {1'b0, dv_len_ff[k]});
      assign rem_in = take ? rem_t - {1'b0, dv_len_ff[k]} : rem_t;
      assign q_in   = {dv_q_ff[k][QB-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ctx_ff[k+1]   <= dv_ctx_ff[k];
            dv_len_ff[k+1]   <= dv_len_ff[k];
            dv_short_ff[k+1] <= dv_short_ff[k];
            dv_rem_ff[k+1]   <= rem_in[W-1:0];   // remainder stays below len
            dv_q_ff[k+1]     <= q_in;
         end
      end
   end

   // ---------------- normalize multiply ----------------
   logic [2:0][XW-1:0] mp_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mp_in[i] = $signed(dv_ctx_ff[QB].a[i]) * $signed({1'b0, dv_q_ff[QB]});
      end
   end

   logic               mu_vld_ff;
   ctx_type            mu_ctx_ff;
   logic [W-1:0]       mu_len_ff;
   logic               mu_short_ff;
   logic [2:0][XW-1:0] mu_mp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_vld_ff <= 1'b0;
      end else if (adv) begin
         mu_vld_ff <= dv_vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_ctx_ff   <= dv_ctx_ff[QB];
         mu_len_ff   <= dv_len_ff[QB];
         mu_short_ff <= dv_short_ff[QB];
         mu_mp_ff    <= mp_in;
      end
   end

   // ---------------- result select and output beat ----------------
   logic [2:0][W:0]   n_w;
   logic [3:0][W-1:0] r_in;
   logic [W-1:0]      sc_in;
   logic              ts_in;
   logic              sat_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_w[i] = clip_w(trunc_shift($signed(mu_mp_ff[i])));
      end
      r_in   = mu_ctx_ff.f[3:0];
      sc_in  = mu_ctx_ff.f[4];
      ts_in  = 1'b0;
      sat_in = mu_ctx_ff.fsat;
      case (mu_ctx_ff.mode)
         MODE_LENGTH: begin
            // Root can exceed the positive range only through its top bit.
            r_in   = '0;
            sat_in = mu_len_ff[W-1];
            sc_in  = mu_len_ff[W-1] ? {1'b0, {(W-1){1'b1}}} : mu_len_ff;
         end
         MODE_NORM: begin
            sc_in = '0;
            if (mu_short_ff) begin
               r_in   = mu_ctx_ff.a;
               ts_in  = 1'b1;
               sat_in = 1'b0;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  r_in[i] = n_w[i][W-1:0];
               end
               r_in[3] = '0;
               sat_in  = n_w[0][W] | n_w[1][W] | n_w[2][W];
            end
         end
         default: begin
         end
      endcase
   end

   logic [3:0][W-1:0] rsp_r_ff;
   logic [W-1:0]      rsp_sc_ff;
   logic              rsp_ts_ff;
   logic              rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= mu_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_r_ff   <= r_in;
         rsp_sc_ff  <= sc_in;
         rsp_ts_ff  <= ts_in;
         rsp_sat_ff <= sat_in;
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.result_x   = rsp_r_ff[0];
   assign rsp_bus.result_y   = rsp_r_ff[1];
   assign rsp_bus.result_z   = rsp_r_ff[2];
   assign rsp_bus.result_w   = rsp_r_ff[3];
   assign rsp_bus.scalar_out = rsp_sc_ff;
   assign rsp_bus.too_short  = rsp_ts_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

endmodule

// ----- hw/rtl/vfa_checker.sv -----
// Port-level checks for the vector ALU, bound to the top level.
module vfa_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic too_short,
   input logic saturated
);

   // Result beat may not vanish while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // Input side only backs up behind a stalled result beat.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // A skipped normalize returns the input and cannot clip.
   a_short_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && too_short |-> !saturated)
      else $error("too_short beat flagged as saturated");

   // Pipe is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind vector4_fixed_point_alu vfa_checker u_vfa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .too_short (rsp_bus.too_short),
   .saturated (rsp_bus.saturated)
);

// ----- tb/sv/vector4_fixed_point_alu_tb.sv -----
// Self-checking testbench for the four-component Q16.16 vector ALU.
`timescale 1ns / 100ps

module vector4_fixed_point_alu_tb import vfa_pkg::*;;

   localparam int  FRAC        = 16;
   localparam int  DRAIN_WAIT  = 90;       // pipe depth is 72, plus margin
   localparam int  CYCLE_LIMIT = 400000;

   typedef struct {
      mode_type          mode;
      logic [3:0][31:0]  a;
      logic [3:0][31:0]  b;
      logic [31:0]       scale;
   } operands_type;

   typedef struct packed {
      logic [31:0] x, y, z, w, scalar;
      logic        too_short, saturated;
   } alu_result_type;

   // Scoreboard: predicts each accepted operand beat, checks result beats in order.
   class vector_alu_scoreboard;
      alu_result_type pending[$];
      eps_type        epsilon;
      int             mismatches;

      function new();
         epsilon    = EPS_RESET;
         mismatches = 0;
      endfunction

      // Clip to signed 32 bits, raising the saturation flag.
      function logic [31:0] clip32(input logic signed [127:0] v, inout logic sat);
         if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
         end
         if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return v[31:0];
      endfunction

      // Drop the fraction bits, truncating toward zero.
      function logic signed [127:0] drop_fraction(input logic signed [127:0] v);
         if (v < 0) return -((-v) >>> FRAC);
         return v >>> FRAC;
      endfunction

      function longint unsigned floor_sqrt(input longint unsigned s);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > s) bitv >>= 2;
         while (bitv != 0) begin
            if (s >= root + bitv) begin
               s    = s - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function alu_result_type compute_alu_result(input operands_type op);
         alu_result_type      r;
         logic signed [127:0] av[4], bv[4], sv, acc;
         longint unsigned     sumsq, len, recip;
         logic                sat;
         sat = 1'b0;
         r   = '0;
         for (int i = 0; i < 4; i++) begin
            av[i] = $signed(op.a[i]);
            bv[i] = $signed(op.b[i]);
         end
         sv = $signed(op.scale);
         sumsq = 0;
         for (int i = 0; i < 3; i++) sumsq += 64'(av[i] * av[i]);
         len = floor_sqrt(sumsq);
         case (op.mode)
            MODE_DOT: begin
               acc = 0;
               for (int i = 0; i < 4; i++) acc += av[i] * bv[i];
               r.scalar = clip32(drop_fraction(acc), sat);
            end
            MODE_SCALE: begin
               r.x = clip32(drop_fraction(av[0] * sv), sat);
               r.y = clip32(drop_fraction(av[1] * sv), sat);
               r.z = clip32(drop_fraction(av[2] * sv), sat);
               r.w = clip32(drop_fraction(av[3] * sv), sat);
            end
            MODE_NEGATE: begin
               r.x = clip32(-av[0], sat);
               r.y = clip32(-av[1], sat);
               r.z = clip32(-av[2], sat);
               r.w = clip32(-av[3], sat);
            end
            MODE_SUB: begin
               r.x = clip32(av[0] - bv[0], sat);
               r.y = clip32(av[1] - bv[1], sat);
               r.z = clip32(av[2] - bv[2], sat);
               r.w = clip32(av[3] - bv[3], sat);
            end
            MODE_ADD: begin
               r.x = clip32(av[0] + bv[0], sat);
               r.y = clip32(av[1] + bv[1], sat);
               r.z = clip32(av[2] + bv[2], sat);
               r.w = clip32(av[3] + bv[3], sat);
            end
            MODE_LENGTH: r.scalar = clip32($signed({64'd0, len}), sat);
            MODE_NORM: begin
               if (len == 0 || len < 64'(epsilon)) begin
                  // too short: a passes through untouched
                  r.too_short = 1'b1;
                  r.x = op.a[0]; r.y = op.a[1]; r.z = op.a[2]; r.w = op.a[3];
               end else begin
                  recip = (64'd1 << (2 * FRAC)) / len;
                  r.x = clip32(drop_fraction(av[0] * $signed({64'd0, recip})), sat);
                  r.y = clip32(drop_fraction(av[1] * $signed({64'd0, recip})), sat);
                  r.z = clip32(drop_fraction(av[2] * $signed({64'd0, recip})), sat);
               end
            end
            default: begin   // cross, w cleared
               r.x = clip32(drop_fraction(av[1] * bv[2] - av[2] * bv[1]), sat);
               r.y = clip32(drop_fraction(av[2] * bv[0] - av[0] * bv[2]), sat);
               r.z = clip32(drop_fraction(av[0] * bv[1] - av[1] * bv[0]), sat);
            end
         endcase
         r.saturated = sat;
         return r;
      endfunction

      function void note_operands(input operands_type op);
         pending.push_back(compute_alu_result(op));
      endfunction

      function void check_result(input alu_result_type got);
         alu_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat x=%h", got.x);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: exp x=%h y=%h z=%h w=%h s=%h ts=%b sat=%b\n",
                        want.x, want.y, want.z, want.w, want.scalar,
                        want.too_short, want.saturated,
                        "                 got x=%h y=%h z=%h w=%h s=%h ts=%b sat=%b",
                        got.x, got.y, got.z, got.w, got.scalar,
                        got.too_short, got.saturated);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   vfa_req_if #(.W(32)) req_bus ();
   vfa_rsp_if #(.W(32)) rsp_bus ();
   vfa_csr_if           csr_bus ();

   vector4_fixed_point_alu #(.FRACTION_BITS(16), .COMPONENT_WIDTH(32)) dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   vector_alu_scoreboard results_sb = new();

   int send_idle_pct;    // chance per cycle that the operand side holds off
   int recv_idle_pct;    // chance per cycle that the result side stalls
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the pipe hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Result side: sample just before the edge (inputs only move at posedge),
   // commit on the edge, then pick the next ready.
   initial begin
      alu_result_type got;
      logic           beat;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         beat = !reset && rsp_bus.valid && rsp_bus.ready;
         got.x         = rsp_bus.result_x;
         got.y         = rsp_bus.result_y;
         got.z         = rsp_bus.result_z;
         got.w         = rsp_bus.result_w;
         got.scalar    = rsp_bus.scalar_out;
         got.too_short = rsp_bus.too_short;
         got.saturated = rsp_bus.saturated;
         @(posedge clock);
         if (beat) results_sb.check_result(got);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Hold valid until the beat is taken; ready is stable between negedge and posedge.
   task automatic wait_req_beat();
      logic beat;
      do begin
         @(negedge clock);
         beat = req_bus.ready;
         @(posedge clock);
      end while (!beat);
   endtask

   task automatic send_operands(input operands_type op);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= op.mode;
      req_bus.a_x       <= op.a[0];
      req_bus.a_y       <= op.a[1];
      req_bus.a_z       <= op.a[2];
      req_bus.a_w       <= op.a[3];
      req_bus.b_x       <= op.b[0];
      req_bus.b_y       <= op.b[1];
      req_bus.b_z       <= op.b[2];
      req_bus.b_w       <= op.b[3];
      req_bus.scalar_in <= op.scale;
      wait_req_beat();
      results_sb.note_operands(op);
   endtask

   // Quiesce: valid down, every result home, then let the pipe empty.
   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_epsilon(input eps_type value);
      logic beat;
      csr_bus.valid             <= 1'b1;
      csr_bus.epsilon_threshold <= value;
      do begin
         @(negedge clock);
         beat = csr_bus.ready;
         @(posedge clock);
      end while (!beat);
      csr_bus.valid <= 1'b0;
      results_sb.epsilon = value;
   endtask

   // Mix of magnitudes: full range, mid, tiny (near epsilon), and the two bounds.
   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         3:       return 32'($urandom_range(0, 64)) - 32'd32;
         4:       return 32'h8000_0000;
         default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : $urandom;
      endcase
   endfunction

   function automatic operands_type random_operands();
      operands_type op;
      op.mode = mode_type'($urandom_range(0, 7));
      for (int i = 0; i < 4; i++) begin
         op.a[i] = pick_component();
         op.b[i] = pick_component();
      end
      op.scale = pick_component();
      return op;
   endfunction

   function automatic operands_type make_op(input mode_type m, input logic [31:0] av,
                                            input logic [31:0] bv, input logic [31:0] s);
      operands_type op;
      op.mode  = m;
      op.a     = {4{av}};
      op.b     = {4{bv}};
      op.scale = s;
      return op;
   endfunction

   initial begin
      operands_type op;
      reset                     <= 1'b1;
      req_bus.valid             <= 1'b0;
      req_bus.mode              <= MODE_DOT;
      req_bus.a_x               <= '0;
      req_bus.a_y               <= '0;
      req_bus.a_z               <= '0;
      req_bus.a_w               <= '0;
      req_bus.b_x               <= '0;
      req_bus.b_y               <= '0;
      req_bus.b_z               <= '0;
      req_bus.b_w               <= '0;
      req_bus.scalar_in         <= '0;
      csr_bus.valid             <= 1'b0;
      csr_bus.epsilon_threshold <= '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset epsilon of 7.
      send_operands(make_op(MODE_DOT,    32'h7fff_ffff, 32'h7fff_ffff, 0));  // saturates high
      send_operands(make_op(MODE_DOT,    32'h8000_0000, 32'h7fff_ffff, 0));  // saturates low
      send_operands(make_op(MODE_DOT,    32'hffff_ffff, 32'h0000_0001, 0));  // truncates to 0
      send_operands(make_op(MODE_SCALE,  32'h0001_0000, 0, 32'h8000_0000));
      send_operands(make_op(MODE_SCALE,  32'h7fff_ffff, 0, 32'h7fff_ffff));
      send_operands(make_op(MODE_SCALE,  32'hffff_fffd, 0, 32'h0000_8000));
      send_operands(make_op(MODE_NEGATE, 32'h8000_0000, 0, 0));             // -min clips
      send_operands(make_op(MODE_NEGATE, 32'h7fff_ffff, 0, 0));
      send_operands(make_op(MODE_SUB,    32'h8000_0000, 32'h0000_0001, 0));
      send_operands(make_op(MODE_SUB,    32'h7fff_ffff, 32'h8000_0000, 0));
      send_operands(make_op(MODE_ADD,    32'h7fff_ffff, 32'h7fff_ffff, 0));
      send_operands(make_op(MODE_ADD,    32'h8000_0000, 32'hffff_ffff, 0));
      send_operands(make_op(MODE_LENGTH, 32'h8000_0000, 0, 0));             // length clips
      send_operands(make_op(MODE_LENGTH, 32'h0003_0000, 0, 0));
      send_operands(make_op(MODE_NORM,   32'h0000_0000, 0, 0));             // zero length
      send_operands(make_op(MODE_NORM,   32'h0000_0003, 0, 0));             // below epsilon
      send_operands(make_op(MODE_NORM,   32'h0000_0004, 0, 0));             // still below epsilon (length 6)
      send_operands(make_op(MODE_NORM,   32'h8000_0000, 0, 0));
      send_operands(make_op(MODE_NORM,   32'h0001_0000, 0, 0));
      send_operands(make_op(MODE_CROSS,  32'h7fff_ffff, 32'h8000_0000, 0));
      op = make_op(MODE_CROSS, 32'h0001_0000, 32'h0002_0000, 0);
      op.a[1] = 32'h0003_0000;
      op.b[0] = 32'hfffe_0000;
      send_operands(op);
      drain_pipe();

      // eps = 0: only a zero length counts as short.
      write_epsilon(16'd0);
      send_operands(make_op(MODE_NORM, 32'h0000_0000, 0, 0));
      send_operands(make_op(MODE_NORM, 32'h0000_0001, 0, 0));

      for (int phase = 0; phase < 3; phase++) begin
         drain_pipe();   // sender holds until every result has come back
         case (phase)
            0:       write_epsilon(16'hffff);
            1:       write_epsilon(16'd1);
            default: write_epsilon(eps_type'($urandom_range(2, 300)));
         endcase
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 53 : 0;
         recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 23 : 0;
         for (int n = 0; n < 130; n++) begin
            op = random_operands();
            // stretches of back-to-back beats in the idling phases too
            if (phase != 2 && n % 40 == 20) send_idle_pct = 0;
            if (phase != 2 && n % 40 == 30) send_idle_pct = (phase == 0) ? 23 : 53;
            send_operands(op);
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (results_sb.mismatches == 0 && results_sb.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- vector4_fixed_point_alu.f -----
hw/rtl/vfa_pkg.sv
hw/rtl/vfa_if.sv
hw/rtl/vector4_fixed_point_alu.sv
hw/rtl/vfa_checker.sv
tb/sv/vector4_fixed_point_alu_tb.sv
